[design/bdpc_pkg.sv]
`default_nettype none

package bdpc_pkg;

  localparam int unsigned DEF_VALUE_WIDTH = 40;
  localparam int unsigned COUNT_WIDTH     = 12;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

endpackage

`default_nettype wire

[design/bdpc_div.sv]
`default_nettype none

module bdpc_div #(
  parameter int unsigned W = bdpc_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);
  import bdpc_pkg::*;

  localparam int unsigned SW = $clog2(W);
  localparam logic [SW-1:0] LAST_STEP = SW'(W - 1);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dsr_r;
  logic [SW-1:0] step_r;
  logic          busy_r;
  logic          done_r;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_step;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    ge       = (shifted >= {1'b0, dsr_r});
    diff     = shifted - {1'b0, dsr_r};
    rem_step = ge ? diff[W-1:0] : shifted[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_step;
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[design/bounded_divisor_pair_count_core.sv]
`default_nettype none
// out_valid rises after the walk over candidates d >= max(lower_bound, 1) with d*d < value;
//   the walk ends at the first d with d*d >= value.
// Each candidate takes one restoring division on the shared divider, one bit a cycle.
// Flow: one item at a time; in_stall stays high until the result beat is taken.
// Reset: synchronous, active low; clears the sequencer, divider control and out_valid.

module bounded_divisor_pair_count_core #(
  parameter int unsigned VALUE_WIDTH = bdpc_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [VALUE_WIDTH-1:0]             in_value,
  input  wire logic [VALUE_WIDTH-1:0]             in_lower_bound,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [bdpc_pkg::COUNT_WIDTH-1:0]        out_pair_count
);
  import bdpc_pkg::*;

  localparam int unsigned W = VALUE_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [W-1:0]           n_r, n_nxt;
  logic [W-1:0]           d_r, d_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   start_r, start_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   div_done;
  logic [W-1:0]           div_quo;
  logic [W-1:0]           div_rem;
  logic                   in_take;
  logic                   below_root;

  bdpc_div #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (n_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_take = in_valid && (state_r == S_IDLE);

  // d*d < n exactly when d is below n/d
  assign below_root = (d_r < div_quo) || ((d_r == div_quo) && (div_rem != '0));

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    cnt_nxt       = cnt_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          n_nxt     = in_value;
          d_nxt     = (in_lower_bound == '0) ? W'(1) : in_lower_bound;
          cnt_nxt   = '0;
          start_nxt = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (below_root) begin
            if ((div_rem == '0) && (cnt_r != COUNT_MAX)) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            d_nxt     = d_r + 1'b1;
            start_nxt = 1'b1;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_pair_count = cnt_r;

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result beat pending while input is open");

  a_take_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> start_r)
    else $error("accepted beat did not start the divider");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the division state");

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && $past(state_r) == S_DIV) |-> (cnt_r >= $past(cnt_r)))
    else $error("pair count fell during an item");

endmodule

`default_nettype wire
